FILE: src/swpt_pkg.sv
// swpt_pkg: shared sizes, types and codes for the sliding window peak tracker.
// Used by every module of the block except swpt_ram; depends on nothing.
package swpt_pkg;

  localparam int unsigned MAX_WINDOW  = 256;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned ADDR_W      = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W       = ADDR_W + 1;
  localparam int unsigned LEN_REG_W   = 9;
  localparam int unsigned SUM_W       = SAMPLE_BITS + ADDR_W;
  localparam int unsigned DIV_CNT_W   = $clog2(SUM_W);
  localparam int unsigned REM_W       = LEN_W + 1;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [LEN_REG_W-1:0] RESET_LENGTH = LEN_REG_W'(256);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic {
    REG_WINDOW_LENGTH,
    REG_CLEAR_VALUE
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic scan_done;
    logic div_last;
  } status_t;

endpackage

FILE: src/sliding_window_peak_tracker_core.sv
// Sliding window peak tracker: max, min and truncated mean over a ring of samples.
// Each accepted sample is written, then the whole active window is scanned (one read per cycle)
// and the sum is divided in a 32-step serial divide; a window length of 0 skips scan and divide.
// A new sample is taken only once the previous result is loaded into the output register.
// Reset: async active low; window_length = 256, clear_value = 0, store reads as 0.
// Depends on swpt_pkg, swpt_ctrl, swpt_dp, swpt_ram.
module sliding_window_peak_tracker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [swpt_pkg::SAMPLE_BITS-1:0] sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [swpt_pkg::SAMPLE_BITS-1:0] window_max_o,
  output logic [swpt_pkg::SAMPLE_BITS-1:0] window_min_o,
  output logic [swpt_pkg::SAMPLE_BITS-1:0] window_mean_o,
  // APB-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [swpt_pkg::PDATA_W-1:0]  pwdata,
  output logic [swpt_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned LW = swpt_pkg::LEN_W;

  // Configuration registers. Register index is address bit 2 (byte offsets 0 and 4).
  logic [swpt_pkg::LEN_REG_W-1:0] window_length_q;
  swpt_pkg::sample_t              clear_value_q;
  logic                           cfg_wr;
  swpt_pkg::reg_idx_e             cfg_idx;
  logic [LW-1:0]                  active_len;

  swpt_pkg::cmd_t    cmd;
  swpt_pkg::status_t status;
  swpt_pkg::sample_t max_s, min_s, mean_s;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = swpt_pkg::reg_idx_e'(paddr[swpt_pkg::PADDR_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= swpt_pkg::RESET_LENGTH;
      clear_value_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        swpt_pkg::REG_WINDOW_LENGTH: window_length_q <= pwdata[swpt_pkg::LEN_REG_W-1:0];
        swpt_pkg::REG_CLEAR_VALUE:   clear_value_q   <= pwdata[swpt_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      swpt_pkg::REG_WINDOW_LENGTH: prdata = swpt_pkg::PDATA_W'(window_length_q);
      swpt_pkg::REG_CLEAR_VALUE:   prdata = swpt_pkg::PDATA_W'(clear_value_q);
      default:                     prdata = '0;
    endcase
  end

  // A length above the store depth is clamped; the register keeps what was written.
  assign active_len = (int'(window_length_q) > int'(swpt_pkg::MAX_WINDOW)) ?
                      LW'(swpt_pkg::MAX_WINDOW) : LW'(window_length_q);

  swpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Any configuration write empties the store (fill mark and head back to zero);
  // unwritten entries then read as clear_value, so no clearing pass is needed.
  swpt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .clear_i      (cfg_wr),
    .len_i        (active_len),
    .clear_value_i(clear_value_q),
    .sample_i     (swpt_pkg::sample_t'(sample_i)),
    .window_max_o (max_s),
    .window_min_o (min_s),
    .window_mean_o(mean_s)
  );

  assign window_max_o  = max_s;
  assign window_min_o  = min_s;
  assign window_mean_o = mean_s;

endmodule

FILE: src/swpt_ram.sv
// swpt_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module swpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/swpt_dp.sv
// swpt_dp: datapath - sample store, window scan (max/min/sum) and serial divider.
// Depends on swpt_pkg and swpt_ram.
module swpt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swpt_pkg::cmd_t                cmd_i,
  output swpt_pkg::status_t             status_o,
  input  logic                          clear_i,
  input  logic [swpt_pkg::LEN_W-1:0]    len_i,
  input  swpt_pkg::sample_t             clear_value_i,
  input  swpt_pkg::sample_t             sample_i,
  output swpt_pkg::sample_t             window_max_o,
  output swpt_pkg::sample_t             window_min_o,
  output swpt_pkg::sample_t             window_mean_o
);

  localparam int unsigned AW = swpt_pkg::ADDR_W;
  localparam int unsigned LW = swpt_pkg::LEN_W;
  localparam int unsigned SW = swpt_pkg::SUM_W;
  localparam int unsigned RW = swpt_pkg::REM_W;
  localparam int unsigned CW = swpt_pkg::DIV_CNT_W;
  localparam int unsigned DW = swpt_pkg::SAMPLE_BITS;

  // control state
  logic [AW-1:0] head_q, head_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [LW-1:0] addr_q;
  logic          rd_valid_q;
  logic [CW-1:0] cnt_q;

  // payload
  logic [LW-1:0]     len_q;
  logic              zero_q;
  logic [LW-1:0]     rd_idx_q;
  swpt_pkg::sample_t max_q, min_q;
  logic signed [SW-1:0] sum_q;
  logic [SW-1:0]     dvd_q;
  logic [RW-1:0]     rem_q;
  logic              neg_q;
  swpt_pkg::sample_t max_out_q, min_out_q, mean_out_q;

  logic              len_zero;
  logic [LW-1:0]     head_inc;
  logic              ram_we, ram_re;
  swpt_pkg::sample_t ram_rdata;
  swpt_pkg::sample_t rd_val;
  logic [RW-1:0]     rem_sh, rem_nx;
  logic              fits;
  logic [SW-1:0]     dvd_nx;
  logic [SW-1:0]     sum_abs;
  logic [SW-1:0]     quot_s;

  assign len_zero = (len_i == '0);
  assign head_inc = {1'b0, head_q} + LW'(1);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (clear_i) begin
      head_d = '0;
      fill_d = '0;
    end else if (cmd_i.start && !len_zero) begin
      head_d = (head_inc == len_i) ? '0 : head_inc[AW-1:0];
      fill_d = (head_inc > fill_q) ? head_inc : fill_q;
    end
  end

  assign ram_we = cmd_i.start && !len_zero;
  assign ram_re = cmd_i.scan && (addr_q < len_q);

  swpt_ram #(
    .WIDTH(DW),
    .DEPTH(swpt_pkg::MAX_WINDOW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i(sample_i),
    .re_i   (ram_re),
    .raddr_i(addr_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // entries at or past the fill mark were never written since the last clear
  assign rd_val = (rd_idx_q < fill_q) ? ram_rdata : clear_value_i;

  // restoring divide step, one quotient bit per cycle
  assign rem_sh = {rem_q[RW-2:0], dvd_q[SW-1]};
  assign fits   = (rem_sh >= {1'b0, len_q});
  assign rem_nx = fits ? (rem_sh - {1'b0, len_q}) : rem_sh;
  assign dvd_nx = {dvd_q[SW-2:0], fits};

  assign sum_abs = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign quot_s  = neg_q ? SW'(-dvd_q) : dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      fill_q     <= '0;
      addr_q     <= '0;
      rd_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (cmd_i.start) begin
        addr_q     <= '0;
        rd_valid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_valid_q <= ram_re;
        if (ram_re) begin
          addr_q <= addr_q + LW'(1);
        end
      end
      if (cmd_i.div_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      len_q  <= len_i;
      zero_q <= len_zero;
      max_q  <= {1'b1, {(DW-1){1'b0}}};
      min_q  <= {1'b0, {(DW-1){1'b1}}};
      sum_q  <= '0;
    end
    if (cmd_i.scan) begin
      if (ram_re) begin
        rd_idx_q <= addr_q;
      end
      if (rd_valid_q) begin
        if (rd_val > max_q) max_q <= rd_val;
        if (rd_val < min_q) min_q <= rd_val;
        sum_q <= sum_q + SW'(rd_val);
      end
    end
    if (cmd_i.div_init) begin
      dvd_q <= sum_abs;
      rem_q <= '0;
      neg_q <= sum_q[SW-1];
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_nx;
      rem_q <= rem_nx;
    end
    if (cmd_i.load_out) begin
      max_out_q  <= zero_q ? '0 : max_q;
      min_out_q  <= zero_q ? '0 : min_q;
      mean_out_q <= zero_q ? '0 : swpt_pkg::sample_t'(quot_s[DW-1:0]);
    end
  end

  assign status_o.len_zero  = len_zero;
  assign status_o.scan_done = (addr_q == len_q) && !rd_valid_q;
  assign status_o.div_last  = (cnt_q == CW'(SW - 1));

  assign window_max_o  = max_out_q;
  assign window_min_o  = min_out_q;
  assign window_mean_o = mean_out_q;

endmodule

FILE: src/swpt_ctrl.sv
// swpt_ctrl: sequencer for accept, scan, divide and result transfer.
// Depends on swpt_pkg.
module swpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  swpt_pkg::status_t status_i,
  output swpt_pkg::cmd_t    cmd_o
);

  swpt_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.len_zero ? swpt_pkg::ST_OUT : swpt_pkg::ST_SCAN;
        end
      end
      swpt_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = swpt_pkg::ST_DIV;
        end
      end
      swpt_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = swpt_pkg::ST_OUT;
        end
      end
      swpt_pkg::ST_OUT: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = swpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swpt_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/swpt_checker.sv
// swpt_checker: port-level assertions for the peak tracker, bound to the top level.
// Depends on swpt_pkg and sliding_window_peak_tracker_core.
module swpt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [swpt_pkg::SAMPLE_BITS-1:0] window_max_o,
  input logic [swpt_pkg::SAMPLE_BITS-1:0] window_min_o,
  input logic [swpt_pkg::SAMPLE_BITS-1:0] window_mean_o
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_max_o)
      && $stable(window_min_o) && $stable(window_mean_o))
    else $error("result dropped or changed while stalled");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(window_min_o) <= $signed(window_max_o))
    else $error("window min above window max");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(window_mean_o) <= $signed(window_max_o)
      && $signed(window_mean_o) >= $signed(window_min_o))
    else $error("window mean outside min..max");

endmodule

bind sliding_window_peak_tracker_core swpt_checker u_swpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .window_max_o (window_max_o),
  .window_min_o (window_min_o),
  .window_mean_o(window_mean_o)
);
